/* sv/fwt_pkg.sv */
// Shared types and constants of the futex wait table.
// Used by fwt_ram users, futex_wait_table_core and fwt_checker; depends on nothing.
package fwt_pkg;

  localparam int SLOTS          = 1024;
  localparam int SLOT_AW        = $clog2(SLOTS);
  localparam int SLOT_CW        = SLOT_AW + 1;
  localparam int THREAD_ID_BITS = 8;
  localparam int MAX_WAKE       = 63;

  localparam int KIND_W   = 3;
  localparam int TID_W    = 8;
  localparam int ADDR_W   = 64;
  localparam int VALUE_W  = 32;
  localparam int WAKE_W   = 6;
  localparam int REQ_W    = 11;
  localparam int DONE_W   = 11;
  localparam int STATUS_W = 2;

  localparam int IN_TDATA_W  = 224;
  localparam int OUT_TDATA_W = 24;

  localparam logic [KIND_W-1:0] KIND_WAIT     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WAKE     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REQUEUE  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CREQUEUE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CANCEL   = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISMATCH = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

  typedef struct packed {
    logic                      valid;
    logic [ADDR_W-1:0]         addr;
    logic [THREAD_ID_BITS-1:0] thread;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

endpackage

/* sv/fwt_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// Self-contained; no package dependencies.
module fwt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/futex_wait_table_core.sv */
// Top level of the futex wait table: slot memory, request sequencer and result register.
// Depends on fwt_pkg and fwt_ram.
//
// The block keeps a table of waiter slots in one memory and handles one request at a time.
// After reset it clears the table, one slot a cycle, before it takes the first request. A wait
// or a compare requeue with a value mismatch, and an unused kind, finish at once: the request
// goes straight to the finishing state, which offers the status transaction as soon as the
// result side is free. Every other request reads the whole table in index order, one slot a
// cycle through the memory's single read port while the result side does not stall a woken
// thread, and then offers its status transaction; the block is ready for the next request in
// the same cycle that the status transaction is offered. Woken threads come out during the
// scan, one transaction each, and every request ends with one status transaction with tlast set.
module futex_wait_table_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // thread_id, wait_address, new_address, current_value, expected_value,
  // wake_count, requeue_count, zero padding
  input  logic [fwt_pkg::IN_TDATA_W-1:0] in_tdata,
  // kind
  input  logic [fwt_pkg::KIND_W-1:0]     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // woken_thread, done_count, status, zero padding
  output logic [fwt_pkg::OUT_TDATA_W-1:0] out_tdata,
  // has_thread
  output logic                           out_tuser,
  output logic                           out_tlast
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [fwt_pkg::SLOT_AW-1:0] clr_idx_r, clr_idx_nxt;
  logic [fwt_pkg::SLOT_CW-1:0] rd_idx_r, rd_idx_nxt;
  logic [fwt_pkg::SLOT_AW-1:0] p1_idx_r, p1_idx_nxt;
  logic v1_r, v1_nxt;

  logic [fwt_pkg::KIND_W-1:0]         req_kind_r, req_kind_nxt;
  logic [fwt_pkg::THREAD_ID_BITS-1:0] req_tid_r, req_tid_nxt;
  logic [fwt_pkg::ADDR_W-1:0]         req_addr_r, req_addr_nxt;
  logic [fwt_pkg::ADDR_W-1:0]         req_naddr_r, req_naddr_nxt;
  logic [fwt_pkg::WAKE_W-1:0]         req_wcnt_r, req_wcnt_nxt;
  logic [fwt_pkg::WAKE_W-1:0]         req_lim_r, req_lim_nxt;
  logic [fwt_pkg::REQ_W-1:0]          req_rcnt_r, req_rcnt_nxt;
  logic                               req_mis_r, req_mis_nxt;

  logic [fwt_pkg::WAKE_W-1:0]  woken_r, woken_nxt;
  logic [fwt_pkg::REQ_W-1:0]   moved_r, moved_nxt;
  logic                        found_r, found_nxt;
  logic                        free_found_r, free_found_nxt;
  logic [fwt_pkg::SLOT_AW-1:0] free_idx_r, free_idx_nxt;
  logic                        removed_r, removed_nxt;

  logic                          out_tvalid_r, out_tvalid_nxt;
  logic                          out_has_r, out_has_nxt;
  logic [fwt_pkg::TID_W-1:0]     out_thread_r, out_thread_nxt;
  logic [fwt_pkg::DONE_W-1:0]    out_done_r, out_done_nxt;
  logic [fwt_pkg::STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic                          out_last_r, out_last_nxt;

  logic                         ram_we;
  logic [fwt_pkg::SLOT_AW-1:0]  ram_waddr;
  logic [fwt_pkg::SLOT_W-1:0]   ram_wdata;
  logic                         ram_re;
  logic [fwt_pkg::SLOT_AW-1:0]  ram_raddr;
  logic [fwt_pkg::SLOT_W-1:0]   ram_rdata;

  fwt_pkg::slot_t rd_slot;
  fwt_pkg::slot_t wr_slot;
  fwt_pkg::slot_t new_slot;
  logic hit_addr;
  logic hit_thr;
  logic out_free;
  logic need_emit;
  logic slot_wr;
  logic proceed;
  logic advance;
  logic in_mis;
  logic [fwt_pkg::WAKE_W-1:0] in_wcnt;
  logic [fwt_pkg::DONE_W:0]   done_sum;
  logic [fwt_pkg::DONE_W-1:0] done_val;

  fwt_ram #(
    .WIDTH(fwt_pkg::SLOT_W),
    .DEPTH(fwt_pkg::SLOTS)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {3'b000, out_status_r, out_done_r, out_thread_r};
  assign out_tuser  = out_has_r;
  assign out_tlast  = out_last_r;

  assign rd_slot  = fwt_pkg::slot_t'(ram_rdata);
  assign hit_addr = rd_slot.valid && (rd_slot.addr == req_addr_r);
  assign hit_thr  = rd_slot.valid && (rd_slot.thread == req_tid_r);
  assign out_free = !out_tvalid_r || out_tready;
  assign in_mis   = (in_tdata[167:136] != in_tdata[199:168]);
  assign in_wcnt  = (32'(in_tdata[205:200]) > fwt_pkg::MAX_WAKE) ?
                    fwt_pkg::WAKE_W'(fwt_pkg::MAX_WAKE) : in_tdata[205:200];
  assign done_sum = (fwt_pkg::DONE_W+1)'(woken_r) + (fwt_pkg::DONE_W+1)'(moved_r);

  always_comb begin
    case (req_kind_r)
      fwt_pkg::KIND_WAKE, fwt_pkg::KIND_REQUEUE, fwt_pkg::KIND_CREQUEUE: begin
        done_val = done_sum[fwt_pkg::DONE_W] ? '1 : done_sum[fwt_pkg::DONE_W-1:0];
      end
      fwt_pkg::KIND_CANCEL: begin
        done_val = fwt_pkg::DONE_W'(removed_r);
      end
      default: begin
        done_val = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    rd_idx_nxt     = rd_idx_r;
    p1_idx_nxt     = p1_idx_r;
    v1_nxt         = v1_r;
    req_kind_nxt   = req_kind_r;
    req_tid_nxt    = req_tid_r;
    req_addr_nxt   = req_addr_r;
    req_naddr_nxt  = req_naddr_r;
    req_wcnt_nxt   = req_wcnt_r;
    req_lim_nxt    = req_lim_r;
    req_rcnt_nxt   = req_rcnt_r;
    req_mis_nxt    = req_mis_r;
    woken_nxt      = woken_r;
    moved_nxt      = moved_r;
    found_nxt      = found_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    removed_nxt    = removed_r;
    out_tvalid_nxt = out_tready ? 1'b0 : out_tvalid_r;
    out_has_nxt    = out_has_r;
    out_thread_nxt = out_thread_r;
    out_done_nxt   = out_done_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = '0;
    need_emit      = 1'b0;
    slot_wr        = 1'b0;
    proceed        = 1'b0;
    advance        = 1'b0;
    wr_slot        = rd_slot;
    new_slot.valid  = 1'b1;
    new_slot.addr   = req_addr_r;
    new_slot.thread = req_tid_r;

    case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_idx_r;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == fwt_pkg::SLOT_AW'(fwt_pkg::SLOTS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          req_kind_nxt   = in_tuser;
          req_tid_nxt    = in_tdata[fwt_pkg::THREAD_ID_BITS-1:0];
          req_addr_nxt   = in_tdata[71:8];
          req_naddr_nxt  = in_tdata[135:72];
          req_wcnt_nxt   = in_wcnt;
          req_lim_nxt    = (in_wcnt == '0) ? fwt_pkg::WAKE_W'(1) : in_wcnt;
          req_rcnt_nxt   = in_tdata[216:206];
          req_mis_nxt    = in_mis && (in_tuser == fwt_pkg::KIND_WAIT ||
                                      in_tuser == fwt_pkg::KIND_CREQUEUE);
          woken_nxt      = '0;
          moved_nxt      = '0;
          found_nxt      = 1'b0;
          free_found_nxt = 1'b0;
          removed_nxt    = 1'b0;
          rd_idx_nxt     = '0;
          v1_nxt         = 1'b0;
          if (req_mis_nxt || in_tuser > fwt_pkg::KIND_CANCEL) begin
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (v1_r) begin
          case (req_kind_r)
            fwt_pkg::KIND_WAIT: begin
              if (hit_thr) begin
                found_nxt = 1'b1;
              end
              if (!rd_slot.valid && !free_found_r) begin
                free_found_nxt = 1'b1;
                free_idx_nxt   = p1_idx_r;
              end
            end
            fwt_pkg::KIND_WAKE: begin
              if (hit_addr && woken_r < req_lim_r) begin
                need_emit     = 1'b1;
                slot_wr       = 1'b1;
                wr_slot.valid = 1'b0;
                if (out_free) begin
                  woken_nxt = woken_r + 1'b1;
                end
              end
            end
            fwt_pkg::KIND_REQUEUE, fwt_pkg::KIND_CREQUEUE: begin
              if (hit_addr) begin
                if (woken_r < req_wcnt_r) begin
                  need_emit     = 1'b1;
                  slot_wr       = 1'b1;
                  wr_slot.valid = 1'b0;
                  if (out_free) begin
                    woken_nxt = woken_r + 1'b1;
                  end
                end else if (moved_r < req_rcnt_r) begin
                  slot_wr      = 1'b1;
                  wr_slot.addr = req_naddr_r;
                  moved_nxt    = moved_r + 1'b1;
                end
              end
            end
            fwt_pkg::KIND_CANCEL: begin
              if (hit_thr && !removed_r) begin
                slot_wr       = 1'b1;
                wr_slot.valid = 1'b0;
                removed_nxt   = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        proceed = !need_emit || out_free;
        if (v1_r && proceed) begin
          if (slot_wr) begin
            ram_we    = 1'b1;
            ram_waddr = p1_idx_r;
            ram_wdata = wr_slot;
          end
          if (need_emit) begin
            out_tvalid_nxt = 1'b1;
            out_has_nxt    = 1'b1;
            out_thread_nxt = fwt_pkg::TID_W'(rd_slot.thread);
            out_done_nxt   = '0;
            out_status_nxt = fwt_pkg::STATUS_OK;
            out_last_nxt   = 1'b0;
          end
        end
        advance = !v1_r || proceed;
        if (advance) begin
          if (rd_idx_r != fwt_pkg::SLOT_CW'(fwt_pkg::SLOTS)) begin
            ram_re     = 1'b1;
            ram_raddr  = rd_idx_r[fwt_pkg::SLOT_AW-1:0];
            p1_idx_nxt = rd_idx_r[fwt_pkg::SLOT_AW-1:0];
            rd_idx_nxt = rd_idx_r + 1'b1;
            v1_nxt     = 1'b1;
          end else begin
            v1_nxt    = 1'b0;
            state_nxt = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_has_nxt    = 1'b0;
          out_thread_nxt = '0;
          out_last_nxt   = 1'b1;
          out_done_nxt   = done_val;
          if (req_mis_r) begin
            out_status_nxt = fwt_pkg::STATUS_MISMATCH;
          end else if (req_kind_r == fwt_pkg::KIND_WAIT && !found_r && !free_found_r) begin
            out_status_nxt = fwt_pkg::STATUS_FULL;
          end else begin
            out_status_nxt = fwt_pkg::STATUS_OK;
          end
          if (req_kind_r == fwt_pkg::KIND_WAIT && !req_mis_r && !found_r && free_found_r) begin
            ram_we    = 1'b1;
            ram_waddr = free_idx_r;
            ram_wdata = new_slot;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_idx_r    <= '0;
      v1_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_idx_r    <= clr_idx_nxt;
      v1_r         <= v1_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r     <= rd_idx_nxt;
    p1_idx_r     <= p1_idx_nxt;
    req_kind_r   <= req_kind_nxt;
    req_tid_r    <= req_tid_nxt;
    req_addr_r   <= req_addr_nxt;
    req_naddr_r  <= req_naddr_nxt;
    req_wcnt_r   <= req_wcnt_nxt;
    req_lim_r    <= req_lim_nxt;
    req_rcnt_r   <= req_rcnt_nxt;
    req_mis_r    <= req_mis_nxt;
    woken_r      <= woken_nxt;
    moved_r      <= moved_nxt;
    found_r      <= found_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    removed_r    <= removed_nxt;
    out_has_r    <= out_has_nxt;
    out_thread_r <= out_thread_nxt;
    out_done_r   <= out_done_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule

/* sv/fwt_checker.sv */
// Port-level assertions for the futex wait table, bound to futex_wait_table_core.
// Depends on fwt_pkg.
module fwt_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [fwt_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tuser,
  input logic                            out_tlast
);

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("stalled result transaction changed");

  // Requests are handled one at a time.
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request accepted while one is in progress");

  // A woken-thread transaction is never the closing one of a request.
  a_thread_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> !out_tlast)
    else $error("woken-thread transaction marked last");

  // A woken-thread transaction carries no count and an ok status.
  a_thread_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[20:8] == 13'd0)
    else $error("woken-thread transaction carries count or status");

  // The block is never ready for a new request while a woken-thread transaction is being offered.
  a_no_start_midscan: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> !in_tready)
    else $error("block idle while a woken thread is still being reported");

endmodule

bind futex_wait_table_core fwt_checker u_fwt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .out_tlast (out_tlast)
);

/* bench/futex_wait_table_core_test.sv */
// Self-checking testbench for futex_wait_table_core: random and directed futex requests
// against a behavioral copy of the waiter table, with random stalls on both streams.
// Depends on fwt_pkg and the futex_wait_table_core RTL.
module futex_wait_table_core_test;

  localparam logic [fwt_pkg::KIND_W-1:0] KIND_UNUSED_LO = 3'd5;
  localparam logic [fwt_pkg::KIND_W-1:0] KIND_UNUSED_HI = 3'd7;
  localparam int RANDOM_ITEMS = 440;
  localparam int DRAIN_CYCLES = 1100;
  localparam int HOLD_AT      = 100;
  localparam int HOLD_CYCLES  = 400;
  localparam int PAD_W        = fwt_pkg::IN_TDATA_W - (fwt_pkg::TID_W + 2 * fwt_pkg::ADDR_W
                                + 2 * fwt_pkg::VALUE_W + fwt_pkg::WAKE_W + fwt_pkg::REQ_W);
  localparam logic [fwt_pkg::ADDR_W-1:0]  ADDR_TOP = '1;
  localparam logic [fwt_pkg::VALUE_W-1:0] INT_MIN  = 32'h8000_0000;
  localparam logic [fwt_pkg::VALUE_W-1:0] INT_MAX  = 32'h7FFF_FFFF;

  typedef struct {
    logic [fwt_pkg::KIND_W-1:0]  kind;
    logic [fwt_pkg::TID_W-1:0]   tid;
    logic [fwt_pkg::ADDR_W-1:0]  addr;
    logic [fwt_pkg::ADDR_W-1:0]  naddr;
    logic [fwt_pkg::VALUE_W-1:0] cur;
    logic [fwt_pkg::VALUE_W-1:0] expv;
    logic [fwt_pkg::WAKE_W-1:0]  wcnt;
    logic [fwt_pkg::REQ_W-1:0]   rcnt;
    int                          gap;
    bit                          drain;
  } futex_req_t;

  typedef struct {
    bit                           has_thread;
    logic [fwt_pkg::TID_W-1:0]    thread;
    logic [fwt_pkg::DONE_W-1:0]   done;
    logic [fwt_pkg::STATUS_W-1:0] status;
    bit                           last;
  } futex_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [fwt_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic [fwt_pkg::KIND_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [fwt_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;

  futex_wait_table_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  futex_req_t    request_q[$];
  futex_result_t pending_results[$];
  bit                           waiter_valid [fwt_pkg::SLOTS];
  logic [fwt_pkg::ADDR_W-1:0]   waiter_addr  [fwt_pkg::SLOTS];
  logic [fwt_pkg::TID_W-1:0]    waiter_tid   [fwt_pkg::SLOTS];
  logic [fwt_pkg::ADDR_W-1:0]   addr_pool [5];

  int  errors = 0;
  int  results_predicted = 0;
  int  results_seen = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  tx_calm = 1'b0;
  bit  tx_armed = 1'b0;
  int  tx_wait = 0;
  bit  tx_go;
  bit  rx_calm = 1'b0;
  int  rx_stall = 0;

  task automatic push_result(input bit has, input logic [fwt_pkg::TID_W-1:0] thr,
                             input int done, input logic [fwt_pkg::STATUS_W-1:0] st,
                             input bit last);
    futex_result_t r;
    r.has_thread = has;
    r.thread     = thr;
    r.done       = (done > 2047) ? 11'd2047 : done[fwt_pkg::DONE_W-1:0];
    r.status     = st;
    r.last       = last;
    pending_results.push_back(r);
    results_predicted++;
  endtask

  // Applies one request to the table copy and queues every result it causes.
  task automatic futex_table_apply(input futex_req_t q);
    int  woke;
    int  moved;
    int  lim;
    bit  present;
    bit  placed;
    woke = 0;
    moved = 0;
    present = 1'b0;
    placed = 1'b0;
    case (q.kind)
      fwt_pkg::KIND_WAIT: begin
        if (q.cur != q.expv) begin
          push_result(1'b0, '0, 0, fwt_pkg::STATUS_MISMATCH, 1'b1);
        end else begin
          for (int i = 0; i < fwt_pkg::SLOTS; i++)
            if (waiter_valid[i] && waiter_tid[i] == q.tid) present = 1'b1;
          if (!present) begin
            for (int i = 0; i < fwt_pkg::SLOTS; i++)
              if (!placed && !waiter_valid[i]) begin
                waiter_valid[i] = 1'b1;
                waiter_addr[i]  = q.addr;
                waiter_tid[i]   = q.tid;
                placed = 1'b1;
              end
          end
          push_result(1'b0, '0, 0,
                      (present || placed) ? fwt_pkg::STATUS_OK : fwt_pkg::STATUS_FULL, 1'b1);
        end
      end
      fwt_pkg::KIND_WAKE: begin
        lim = (q.wcnt == '0) ? 1 : int'(q.wcnt);
        for (int i = 0; i < fwt_pkg::SLOTS; i++)
          if (woke < lim && waiter_valid[i] && waiter_addr[i] == q.addr) begin
            waiter_valid[i] = 1'b0;
            push_result(1'b1, waiter_tid[i], 0, fwt_pkg::STATUS_OK, 1'b0);
            woke++;
          end
        push_result(1'b0, '0, woke, fwt_pkg::STATUS_OK, 1'b1);
      end
      fwt_pkg::KIND_REQUEUE, fwt_pkg::KIND_CREQUEUE: begin
        if (q.kind == fwt_pkg::KIND_CREQUEUE && q.cur != q.expv) begin
          push_result(1'b0, '0, 0, fwt_pkg::STATUS_MISMATCH, 1'b1);
        end else begin
          for (int i = 0; i < fwt_pkg::SLOTS; i++)
            if (waiter_valid[i] && waiter_addr[i] == q.addr) begin
              if (woke < int'(q.wcnt)) begin
                waiter_valid[i] = 1'b0;
                push_result(1'b1, waiter_tid[i], 0, fwt_pkg::STATUS_OK, 1'b0);
                woke++;
              end else if (moved < int'(q.rcnt)) begin
                waiter_addr[i] = q.naddr;
                moved++;
              end
            end
          push_result(1'b0, '0, woke + moved, fwt_pkg::STATUS_OK, 1'b1);
        end
      end
      fwt_pkg::KIND_CANCEL: begin
        for (int i = 0; i < fwt_pkg::SLOTS; i++)
          if (!placed && waiter_valid[i] && waiter_tid[i] == q.tid) begin
            waiter_valid[i] = 1'b0;
            placed = 1'b1;
          end
        push_result(1'b0, '0, int'(placed), fwt_pkg::STATUS_OK, 1'b1);
      end
      default: push_result(1'b0, '0, 0, fwt_pkg::STATUS_OK, 1'b1);
    endcase
  endtask

  function automatic futex_req_t make_req(
      input logic [fwt_pkg::KIND_W-1:0] kind, input logic [fwt_pkg::TID_W-1:0] tid,
      input logic [fwt_pkg::ADDR_W-1:0] addr, input logic [fwt_pkg::ADDR_W-1:0] naddr,
      input logic [fwt_pkg::VALUE_W-1:0] cur, input logic [fwt_pkg::VALUE_W-1:0] expv,
      input logic [fwt_pkg::WAKE_W-1:0] wcnt, input logic [fwt_pkg::REQ_W-1:0] rcnt);
    futex_req_t q;
    q.kind  = kind;
    q.tid   = tid;
    q.addr  = addr;
    q.naddr = naddr;
    q.cur   = cur;
    q.expv  = expv;
    q.wcnt  = wcnt;
    q.rcnt  = rcnt;
    q.gap   = tx_calm ? 0 : int'($urandom_range(0, 15));
    q.drain = 1'b0;
    return q;
  endfunction

  function automatic logic [fwt_pkg::ADDR_W-1:0] pick_addr();
    if ($urandom_range(0, 9) != 0) return addr_pool[$urandom_range(0, 4)];
    return {$urandom, $urandom};
  endfunction

  function automatic logic [fwt_pkg::TID_W-1:0] pick_tid();
    if ($urandom_range(0, 3) != 0) return fwt_pkg::TID_W'($urandom_range(0, 63));
    return fwt_pkg::TID_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [fwt_pkg::REQ_W-1:0] pick_rcnt();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return fwt_pkg::REQ_W'($urandom_range(0, 8));
    if (r < 95) return fwt_pkg::REQ_W'($urandom_range(9, 1023));
    return 11'd1024;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  // Driver: offers the head of request_q after its idle gap and predicts on acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      tx_armed = 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        futex_table_apply(request_q.pop_front());
        tx_armed = 1'b0;
      end
      if (!(in_tvalid && !in_tready)) begin
        tx_go = 1'b0;
        if (request_q.size() != 0) begin
          if (!tx_armed) begin
            tx_wait = request_q[0].gap;
            tx_armed = 1'b1;
          end
          if (tx_wait != 0) begin
            tx_wait--;
          end else if (!request_q[0].drain || results_predicted == results_seen) begin
            tx_go = 1'b1;
            in_tdata <= {{PAD_W{1'b0}}, request_q[0].rcnt, request_q[0].wcnt,
                         request_q[0].expv, request_q[0].cur, request_q[0].naddr,
                         request_q[0].addr, request_q[0].tid};
            in_tuser <= request_q[0].kind;
          end
        end
        in_tvalid <= tx_go;
      end
    end
  end

  // Monitor: checks every result transaction against the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          $error("result transaction with no prediction pending");
          errors++;
        end else begin
          futex_result_t want;
          want = pending_results.pop_front();
          check_field("has_thread", int'(want.has_thread), int'(out_tuser));
          check_field("woken_thread", int'(want.thread), int'(out_tdata[7:0]));
          check_field("done_count", int'(want.done), int'(out_tdata[18:8]));
          check_field("status", int'(want.status), int'(out_tdata[20:19]));
          check_field("last", int'(want.last), int'(out_tlast));
        end
        if (results_seen % 64 == 0) rx_calm = ($urandom_range(0, 3) == 0);
        results_seen <= results_seen + 1;
        rx_stall = rx_calm ? 0 : int'($urandom_range(0, 15));
      end else if (rx_stall != 0) begin
        rx_stall--;
      end
      out_tready <= (rx_stall == 0) && (hold_left == 0);
    end
  end

  // One long receiver hold-off while the sender keeps offering requests.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  initial begin
    #50_000_000;
    $display("FAIL futex_wait_table_core");
    $finish;
  end

  initial begin
    int  n;
    int  r;
    futex_req_t q;
    logic [fwt_pkg::VALUE_W-1:0] v;

    addr_pool[0] = '0;
    addr_pool[1] = ADDR_TOP;
    addr_pool[2] = 64'h5;
    addr_pool[3] = {$urandom, $urandom};
    addr_pool[4] = {$urandom, $urandom};

    request_q.push_back(make_req(fwt_pkg::KIND_WAKE, '0, '0, '0, '0, '0, '0, '0));
    request_q.push_back(make_req(fwt_pkg::KIND_WAIT, '0, '0, '0, INT_MIN, INT_MIN, '0, '0));
    request_q.push_back(make_req(fwt_pkg::KIND_WAIT, 8'd255, ADDR_TOP, '0, INT_MAX, INT_MAX,
                                 6'd63, 11'd1024));
    request_q.push_back(make_req(fwt_pkg::KIND_WAIT, 8'd255, 64'h5, '0, '0, '0, '0, '0));
    request_q.push_back(make_req(fwt_pkg::KIND_WAIT, 8'd1, '0, '0, '0, '1, '0, '0));
    request_q.push_back(make_req(fwt_pkg::KIND_WAIT, 8'd17, '0, '0, '1, '1, '0, '0));
    request_q.push_back(make_req(fwt_pkg::KIND_WAIT, 8'd18, '0, '0, '1, '1, '0, '0));
    request_q.push_back(make_req(fwt_pkg::KIND_WAIT, 8'd19, '0, '0, '1, '1, '0, '0));
    request_q.push_back(make_req(fwt_pkg::KIND_REQUEUE, '0, '0, ADDR_TOP, '0, '0, '0, 11'd1));
    request_q.push_back(make_req(fwt_pkg::KIND_CREQUEUE, '0, '0, 64'h5, INT_MAX, INT_MIN,
                                 6'd63, 11'd1024));
    request_q.push_back(make_req(fwt_pkg::KIND_CREQUEUE, '0, '0, 64'h5, 32'd7, 32'd7, 6'd1,
                                 11'd1024));
    request_q.push_back(make_req(fwt_pkg::KIND_WAKE, '0, ADDR_TOP, '0, '0, '0, '0, '0));
    request_q.push_back(make_req(fwt_pkg::KIND_WAKE, '0, ADDR_TOP, '0, '0, '0, 6'd63, '0));
    request_q.push_back(make_req(fwt_pkg::KIND_CANCEL, 8'd19, '0, '0, '0, '0, '0, '0));
    request_q.push_back(make_req(fwt_pkg::KIND_CANCEL, 8'd19, '0, '0, '0, '0, '0, '0));
    request_q.push_back(make_req(fwt_pkg::KIND_WAIT, 8'd170, 64'h5, '0, '0, '0, '0, '0));
    request_q.push_back(make_req(fwt_pkg::KIND_REQUEUE, '0, 64'h5, ADDR_TOP, '0, '0, 6'd63,
                                 11'd1024));
    request_q.push_back(make_req(fwt_pkg::KIND_REQUEUE, '0, 64'h1234, '0, '0, '0, '0, '0));
    for (int k = int'(KIND_UNUSED_LO); k <= int'(KIND_UNUSED_HI); k++)
      request_q.push_back(make_req(fwt_pkg::KIND_W'(k), fwt_pkg::TID_W'($urandom),
                                   {$urandom, $urandom}, {$urandom, $urandom},
                                   $urandom, $urandom, fwt_pkg::WAKE_W'($urandom),
                                   fwt_pkg::REQ_W'($urandom)));

    n = 0;
    while (n < RANDOM_ITEMS) begin
      if (n % 40 == 0) tx_calm = ($urandom_range(0, 2) == 0);
      r = $urandom_range(0, 99);
      v = $urandom;
      if (r < 42) begin
        q = make_req(fwt_pkg::KIND_WAIT, pick_tid(), pick_addr(), {$urandom, $urandom}, v,
                     ($urandom_range(0, 6) == 0) ? $urandom : v,
                     fwt_pkg::WAKE_W'($urandom), fwt_pkg::REQ_W'($urandom));
      end else if (r < 58) begin
        q = make_req(fwt_pkg::KIND_WAKE, fwt_pkg::TID_W'($urandom), pick_addr(),
                     {$urandom, $urandom}, $urandom, $urandom,
                     fwt_pkg::WAKE_W'(($urandom_range(0, 2) == 0) ?
                                      $urandom_range(0, 3) : $urandom),
                     fwt_pkg::REQ_W'($urandom));
      end else if (r < 82) begin
        q = make_req((r < 72) ? fwt_pkg::KIND_REQUEUE : fwt_pkg::KIND_CREQUEUE,
                     fwt_pkg::TID_W'($urandom), pick_addr(), pick_addr(), v,
                     ($urandom_range(0, 4) == 0) ? $urandom : v,
                     fwt_pkg::WAKE_W'(($urandom_range(0, 2) == 0) ?
                                      $urandom_range(0, 3) : $urandom),
                     pick_rcnt());
      end else if (r < 96) begin
        q = make_req(fwt_pkg::KIND_CANCEL, pick_tid(), {$urandom, $urandom},
                     {$urandom, $urandom}, $urandom, $urandom,
                     fwt_pkg::WAKE_W'($urandom), fwt_pkg::REQ_W'($urandom));
      end else begin
        q = make_req(fwt_pkg::KIND_W'($urandom_range(KIND_UNUSED_HI, KIND_UNUSED_LO)),
                     fwt_pkg::TID_W'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
                     $urandom, $urandom, fwt_pkg::WAKE_W'($urandom),
                     fwt_pkg::REQ_W'($urandom));
      end
      q.drain = (n == 0) || ($urandom_range(0, 29) == 0);
      request_q.push_back(q);
      n++;
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (request_q.size() != 0 || pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS futex_wait_table_core");
    end else begin
      $display("FAIL futex_wait_table_core");
    end
    $finish;
  end

endmodule
